// File: rtl/ipstk_pkg.sv
// Shared types, character codes and classification functions for the infix-to-prefix stack unit.
package ipstk_pkg;

    // Default operator stack depth.
    localparam int STACK_DEPTH_DEF = 32;

    // Character codes.
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // Status codes carried by the final result.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_PAREN    = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN  = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_CHK,
        ST_PUSH,
        ST_FINISH
    } state_t;

    // What the current pop loop is doing.
    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_OP,
        MODE_PAREN,
        MODE_FLUSH
    } mode_t;

    // Letters and digits pass straight through.
    function automatic logic is_operand(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    // Operators of the higher precedence group.
    function automatic logic is_high_op(input logic [7:0] c);
        return c == CH_CARET || c == CH_STAR || c == CH_SLASH || c == CH_PERCENT;
    endfunction

    // Operators of the lower precedence group.
    function automatic logic is_low_op(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

endpackage

// File: rtl/ipstk_if.sv
// Valid/ready channel interfaces for the input characters and the output results.
interface ipstk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface ipstk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       has_char;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, output out_char, output has_char, output out_last,
                    output status, input ready);
    modport sink   (input valid, input out_char, input has_char, input out_last,
                    input status, output ready);
endinterface

// File: rtl/ipstk_mem.sv
// Operator stack memory: one write port, one read port with registered read data.
module ipstk_mem #(
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/infix_to_prefix_stack_unit.sv
// Top level: sequencer of the infix-to-prefix operator stack with its output register.
//
//  Channel   Dir  Payload                               Transfer
//  in_ch     in   in_char[7:0], in_last                 valid && ready
//  out_ch    out  out_char[7:0], has_char, out_last,    valid && ready
//                 status[1:0]
//
// An operand or unknown character goes straight to the finish step and a ')'
// is pushed; another operator or '(' first scans the stack, reading each entry
// and then deciding, since the stack memory has one registered read port. A
// final character also flushes every entry left on the stack.
// Reset clears the stack count, status and output register; no clearing pass.
// A full output register stalls the sequencer only when it must emit.
module infix_to_prefix_stack_unit #(
    parameter int STACK_DEPTH = ipstk_pkg::STACK_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    ipstk_in_if.sink    in_ch,
    ipstk_out_if.source out_ch
);
    import ipstk_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    state_t        state_reg, state_next;
    mode_t         mode_reg, mode_next;
    logic [7:0]    char_reg, char_next;
    logic          last_reg, last_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    err_reg, err_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_char_reg, pend_char_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic          out_has_reg, out_has_next;
    logic          out_last_reg, out_last_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [CW-1:0] count_dec;
    logic          out_free;
    logic          take_emit;
    logic          top_pops;

    ipstk_mem #(.DEPTH(STACK_DEPTH)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (char_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign count_dec = count_reg - CW'(1);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign top_pops  = is_high_op(char_reg) ? (rd_data == CH_CARET) : is_high_op(rd_data);

    // Control and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_NONE;
            count_reg      <= '0;
            err_reg        <= STATUS_OK;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        last_reg       <= last_next;
        pend_char_reg  <= pend_char_next;
        out_char_reg   <= out_char_next;
        out_has_reg    <= out_has_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    // Sequencer: next state, stack access and result emission.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_char_next   = out_char_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        rd_en           = 1'b0;
        rd_addr         = count_dec[AW-1:0];
        take_emit       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    char_next = in_ch.in_char;
                    last_next = in_ch.in_last;
                    mode_next = MODE_NONE;
                    if (is_operand(in_ch.in_char))
                    begin
                        pend_char_next  = in_ch.in_char;
                        pend_valid_next = 1'b1;
                        state_next      = ST_FINISH;
                    end
                    else if (in_ch.in_char == CH_LPAREN)
                    begin
                        mode_next  = MODE_PAREN;
                        state_next = ST_POP_RD;
                    end
                    else if (in_ch.in_char == CH_RPAREN)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (is_high_op(in_ch.in_char) || is_low_op(in_ch.in_char))
                    begin
                        mode_next  = MODE_OP;
                        state_next = ST_POP_RD;
                    end
                    else
                    begin
                        if (err_reg == STATUS_OK)
                        begin
                            err_next = STATUS_UNKNOWN;
                        end
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_POP_RD:
            begin
                if (count_reg == '0)
                begin
                    case (mode_reg)
                        MODE_PAREN:
                        begin
                            if (err_reg == STATUS_OK)
                            begin
                                err_next = STATUS_PAREN;
                            end
                            state_next = ST_FINISH;
                        end
                        MODE_OP:
                        begin
                            state_next = ST_PUSH;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_POP_CHK;
                end
            end

            ST_POP_CHK:
            begin
                case (mode_reg)
                    MODE_PAREN:
                    begin
                        if (rd_data == CH_RPAREN)
                        begin
                            count_next = count_dec;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            take_emit = 1'b1;
                        end
                    end
                    MODE_OP:
                    begin
                        if (top_pops)
                        begin
                            take_emit = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_PUSH;
                        end
                    end
                    MODE_FLUSH:
                    begin
                        if (rd_data == CH_RPAREN)
                        begin
                            if (err_reg == STATUS_OK)
                            begin
                                err_next = STATUS_PAREN;
                            end
                            count_next = count_dec;
                            state_next = ST_POP_RD;
                        end
                        else
                        begin
                            take_emit = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase

                // The popped character becomes pending; the old pending one leaves.
                if (take_emit && (!pend_valid_reg || out_free))
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_char_next   = pend_char_reg;
                        out_has_next    = 1'b1;
                        out_last_next   = 1'b0;
                        out_status_next = STATUS_OK;
                    end
                    pend_char_next  = rd_data;
                    pend_valid_next = 1'b1;
                    count_next      = count_dec;
                    state_next      = ST_POP_RD;
                end
            end

            ST_PUSH:
            begin
                if (count_reg < CW'(STACK_DEPTH))
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else if (err_reg == STATUS_OK)
                begin
                    err_next = STATUS_OVERFLOW;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (last_reg && mode_reg != MODE_FLUSH)
                begin
                    mode_next  = MODE_FLUSH;
                    state_next = ST_POP_RD;
                end
                else if (pend_valid_reg || last_reg)
                begin
                    // The pending character, or a bare end marker, closes the item.
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_char_next   = pend_valid_reg ? pend_char_reg : CH_NUL;
                        out_has_next    = pend_valid_reg;
                        out_last_next   = last_reg;
                        out_status_next = last_reg ? err_reg : STATUS_OK;
                        pend_valid_next = 1'b0;
                        if (last_reg)
                        begin
                            err_next   = STATUS_OK;
                            count_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_char = out_char_reg;
    assign out_ch.has_char = out_has_reg;
    assign out_ch.out_last = out_last_reg;
    assign out_ch.status   = out_status_reg;

endmodule

// File: rtl/ipstk_check.sv
// Port-level assertions for the infix-to-prefix stack unit and their bind.
module ipstk_check (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       has_char,
    input logic       out_last,
    input logic [1:0] status
);
    import ipstk_pkg::*;

    // An accepted character always occupies the sequencer for the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a transfer");

    // A nonzero status appears only on the final result.
    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> (status == STATUS_OK))
        else $error("status on a result that is not the last");

    // A bare end marker is always final and carries a zero character.
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_char) |-> (out_last && out_char == CH_NUL))
        else $error("bare marker that is not final or not zero");

    // A real character is never the zero code.
    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_char) |-> (out_char != CH_NUL))
        else $error("zero character marked valid");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
        else $error("stalled result changed");

endmodule

bind infix_to_prefix_stack_unit ipstk_check u_ipstk_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.out_char),
    .has_char  (out_ch.has_char),
    .out_last  (out_ch.out_last),
    .status    (out_ch.status)
);

// File: bench/testbench.sv
// Self-checking testbench for the infix-to-prefix operator stack unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipstk_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int CHAR_TARGET = 320;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 100;

    // One output transfer as the block presents it.
    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
        logic [1:0] status;
    } result_t;

    // One line of the directed script; known rows carry their single result.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       known;
        result_t    want;
    } script_row_t;

    typedef enum logic [2:0] {
        KIND_OPERAND,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_TIGHT,
        KIND_LOOSE,
        KIND_OTHER
    } char_kind_t;

    localparam result_t NO_RESULT = '0;
    localparam int SCRIPT_ROWS = 25;

    // Single-character cases after reset first, then two short expressions fed right to left.
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{"a",        1'b1, 1'b1, '{"a", 1'b1, 1'b1, STATUS_OK}},
        '{8'h00,      1'b1, 1'b1, '{CH_NUL, 1'b0, 1'b1, STATUS_UNKNOWN}},
        '{8'hFF,      1'b1, 1'b1, '{CH_NUL, 1'b0, 1'b1, STATUS_UNKNOWN}},
        '{CH_LPAREN,  1'b1, 1'b1, '{CH_NUL, 1'b0, 1'b1, STATUS_PAREN}},
        '{CH_RPAREN,  1'b1, 1'b1, '{CH_NUL, 1'b0, 1'b1, STATUS_PAREN}},
        '{CH_PLUS,    1'b1, 1'b1, '{CH_PLUS, 1'b1, 1'b1, STATUS_OK}},
        '{"c",        1'b0, 1'b0, NO_RESULT},
        '{CH_CARET,   1'b0, 1'b0, NO_RESULT},
        '{"b",        1'b0, 1'b0, NO_RESULT},
        '{CH_STAR,    1'b0, 1'b0, NO_RESULT},
        '{"a",        1'b1, 1'b0, NO_RESULT},
        '{"d",        1'b0, 1'b0, NO_RESULT},
        '{CH_PERCENT, 1'b0, 1'b0, NO_RESULT},
        '{"c",        1'b0, 1'b0, NO_RESULT},
        '{CH_SLASH,   1'b0, 1'b0, NO_RESULT},
        '{CH_RPAREN,  1'b0, 1'b0, NO_RESULT},
        '{"b",        1'b0, 1'b0, NO_RESULT},
        '{CH_MINUS,   1'b0, 1'b0, NO_RESULT},
        '{"Z",        1'b0, 1'b0, NO_RESULT},
        '{CH_LPAREN,  1'b0, 1'b0, NO_RESULT},
        '{"A",        1'b0, 1'b0, NO_RESULT},
        '{CH_PLUS,    1'b0, 1'b0, NO_RESULT},
        '{"9",        1'b0, 1'b0, NO_RESULT},
        '{CH_CARET,   1'b0, 1'b0, NO_RESULT},
        '{"0",        1'b1, 1'b0, NO_RESULT}
    };

    logic clk;
    logic rst_n;

    ipstk_in_if  in_bus ();
    ipstk_out_if out_bus ();

    infix_to_prefix_stack_unit #(
        .STACK_DEPTH(DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_bus),
        .out_ch(out_bus)
    );

    // Shadow of the operator stack and the sticky status.
    logic [7:0]  op_mem [DEPTH];
    int unsigned stack_fill = 0;
    logic [1:0]  sticky_status = STATUS_OK;

    // Results of the current character, and results still owed by the block.
    result_t step_out [$];
    result_t owed_results [$];

    // Infix text under construction, left to right.
    logic [7:0] expr_buf [$];

    int mismatches = 0;
    int chars_sent = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int calm_tx = 0;
    int calm_rx = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results still owed", $time, owed_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic char_kind_t classify(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
            return KIND_OPERAND;
        case (c)
            CH_LPAREN:                               return KIND_LPAREN;
            CH_RPAREN:                               return KIND_RPAREN;
            CH_CARET, CH_STAR, CH_SLASH, CH_PERCENT: return KIND_TIGHT;
            CH_PLUS, CH_MINUS:                       return KIND_LOOSE;
            default:                                 return KIND_OTHER;
        endcase
    endfunction

    function automatic logic [7:0] pick_operand();
        case ($urandom_range(0, 2))
            0:       return 8'(8'h61 + $urandom_range(0, 25));
            1:       return 8'(8'h41 + $urandom_range(0, 25));
            default: return 8'(8'h30 + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 5))
            0:       return CH_CARET;
            1:       return CH_STAR;
            2:       return CH_SLASH;
            3:       return CH_PERCENT;
            4:       return CH_PLUS;
            default: return CH_MINUS;
        endcase
    endfunction

    task automatic emit(input logic [7:0] c);
        result_t r;
        r.ch = c;
        r.has = 1'b1;
        r.last = 1'b0;
        r.status = STATUS_OK;
        step_out.push_back(r);
    endtask

    task automatic flag_error(input logic [1:0] code);
        if (sticky_status == STATUS_OK)
            sticky_status = code;
    endtask

    task automatic push_op(input logic [7:0] c);
        if (stack_fill < DEPTH)
        begin
            op_mem[stack_fill] = c;
            stack_fill++;
        end
        else
            flag_error(STATUS_OVERFLOW);
    endtask

    // Works out the results of one accepted character into step_out.
    task automatic convert_char(input logic [7:0] c, input logic last);
        char_kind_t kind;
        logic [7:0] top;
        logic       stop;
        logic       pops;
        result_t    tail;
        kind = classify(c);
        step_out.delete();
        stop = 1'b0;
        case (kind)
            KIND_OPERAND: emit(c);
            KIND_LPAREN:
            begin
                // Pop down to the matching close paren, which is discarded.
                while (stack_fill > 0 && !stop)
                begin
                    stack_fill--;
                    top = op_mem[stack_fill];
                    if (top == CH_RPAREN)
                        stop = 1'b1;
                    else
                        emit(top);
                end
                if (!stop)
                    flag_error(STATUS_PAREN);
            end
            KIND_RPAREN: push_op(c);
            KIND_TIGHT, KIND_LOOSE:
            begin
                // Pop while the top binds tighter, then push.
                while (stack_fill > 0 && !stop)
                begin
                    top = op_mem[stack_fill - 1];
                    pops = (kind == KIND_TIGHT) ? (top == CH_CARET)
                                                : (classify(top) == KIND_TIGHT);
                    if (pops)
                    begin
                        stack_fill--;
                        emit(top);
                    end
                    else
                        stop = 1'b1;
                end
                push_op(c);
            end
            default: flag_error(STATUS_UNKNOWN);
        endcase

        // Flush on the final character; the last result carries the status.
        if (last)
        begin
            while (stack_fill > 0)
            begin
                stack_fill--;
                top = op_mem[stack_fill];
                if (top == CH_RPAREN)
                    flag_error(STATUS_PAREN);
                else
                    emit(top);
            end
            if (step_out.size() == 0)
            begin
                tail = '0;
                tail.ch = CH_NUL;
            end
            else
                tail = step_out.pop_back();
            tail.last = 1'b1;
            tail.status = sticky_status;
            step_out.push_back(tail);
            sticky_status = STATUS_OK;
        end
    endtask

    // Idle length for one transfer, with occasional runs of back-to-back traffic.
    task automatic draw_gap(inout int calm, output int gap);
        if (calm > 0)
        begin
            calm--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 29) == 0)
                calm = 20;
            gap = $urandom_range(0, 9);
        end
    endtask

    // Presents one character and records what it owes once it is accepted.
    task automatic send_char(input logic [7:0] c, input logic last, input logic known,
                             input result_t want);
        int   gap;
        logic took;
        draw_gap(calm_tx, gap);
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.in_char <= c;
        in_bus.in_last <= last;
        // Ready is sampled on the falling edge before the edge that it governs.
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = in_bus.ready;
            @(posedge clk);
        end
        convert_char(c, last);
        if (known)
            owed_results.push_back(want);
        else
            foreach (step_out[i])
                owed_results.push_back(step_out[i]);
        chars_sent++;
    endtask

    // Holds the input quiet until every owed result has arrived.
    task automatic drain();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Operand, operator pairs that pile one operator on the stack each time.
    task automatic fill_stack(input logic [7:0] op, input int pushes);
        for (int k = 0; k < pushes; k++)
        begin
            send_char(pick_operand(), 1'b0, 1'b0, NO_RESULT);
            send_char(op, 1'b0, 1'b0, NO_RESULT);
        end
        send_char(pick_operand(), 1'b1, 1'b0, NO_RESULT);
    endtask

    task automatic build_term(input int nest);
        if (nest < 3 && $urandom_range(0, 3) == 0)
        begin
            expr_buf.push_back(CH_LPAREN);
            build_expr(nest + 1);
            expr_buf.push_back(CH_RPAREN);
        end
        else
            expr_buf.push_back(pick_operand());
    endtask

    task automatic build_expr(input int nest);
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms && expr_buf.size() < 40; i++)
        begin
            if (i > 0)
                expr_buf.push_back(pick_operator());
            build_term(nest);
        end
    endtask

    // Receiver: random back-pressure and the comparison against owed results.
    initial
    begin
        int      gap;
        logic    took;
        result_t got;
        result_t want;
        out_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            draw_gap(calm_rx, gap);
            if (gap > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            // Valid and payload are sampled on the falling edge before the transfer edge.
            took = 1'b0;
            while (!took)
            begin
                @(negedge clk);
                took = out_bus.valid;
                got.ch = out_bus.out_char;
                got.has = out_bus.has_char;
                got.last = out_bus.out_last;
                got.status = out_bus.status;
                @(posedge clk);
            end
            results_seen++;
            if (got.last)
                status_seen[got.status]++;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result char=%02h has=%b last=%b status=%0d",
                         $time, got.ch, got.has, got.last, got.status);
                mismatches++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected char=%02h has=%b last=%b status=%0d, got char=%02h has=%b last=%b status=%0d",
                             $time, want.ch, want.has, want.last, want.status,
                             got.ch, got.has, got.last, got.status);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: reset, directed script, stack-filling runs, then a random mix of fills, raw bytes and expressions.
    initial
    begin
        int pick;
        int idx;
        in_bus.valid <= 1'b0;
        in_bus.in_char <= 8'h00;
        in_bus.in_last <= 1'b0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < SCRIPT_ROWS; r++)
            send_char(SCRIPT[r].ch, SCRIPT[r].last, SCRIPT[r].known, SCRIPT[r].want);
        drain();

        // One push past a full stack, then a stack filled exactly with parens.
        fill_stack(CH_STAR, DEPTH + 1);
        fill_stack(CH_RPAREN, DEPTH);

        while (chars_sent < CHAR_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                case ($urandom_range(0, 2))
                    0:       fill_stack(CH_RPAREN, $urandom_range(DEPTH - 2, DEPTH + 8));
                    1:       fill_stack(CH_MINUS, $urandom_range(DEPTH - 2, DEPTH + 8));
                    default: fill_stack(CH_PERCENT, $urandom_range(DEPTH - 2, DEPTH + 8));
                endcase
            end
            else if (pick < 12)
            begin
                // Raw bytes, with or without an end mark.
                repeat ($urandom_range(1, 6))
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                              1'b0, NO_RESULT);
            end
            else
            begin
                expr_buf.delete();
                build_expr(0);
                // Some expressions lose a character or get one garbled.
                if (pick < 24)
                begin
                    idx = $urandom_range(0, expr_buf.size() - 1);
                    if (pick < 18 && expr_buf.size() > 1)
                        expr_buf.delete(idx);
                    else
                        expr_buf[idx] = 8'($urandom_range(0, 255));
                end
                for (int i = expr_buf.size() - 1; i >= 0; i--)
                    send_char(expr_buf[i], i == 0, 1'b0, NO_RESULT);
            end
            if ($urandom_range(0, 19) == 0)
                drain();
        end

        // Close whatever is left open, then let the block settle.
        send_char("x", 1'b1, 1'b0, NO_RESULT);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d characters and checked %0d results in %0d cycles.",
                 chars_sent, results_seen, cycle_count);
        $display("Final status seen: ok %0d, overflow %0d, paren %0d, unknown %0d.",
                 status_seen[STATUS_OK], status_seen[STATUS_OVERFLOW],
                 status_seen[STATUS_PAREN], status_seen[STATUS_UNKNOWN]);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
rtl/ipstk_pkg.sv
rtl/ipstk_if.sv
rtl/ipstk_mem.sv
rtl/infix_to_prefix_stack_unit.sv
rtl/ipstk_check.sv
bench/testbench.sv
